### rtl/isgbc_pkg.sv
// ----------------------------------------------------------------------------
// isgbc_pkg : shared types and constants for the imu bias calibration block
// Widths, register indexes, phase codes, lane control and result layout.
// ----------------------------------------------------------------------------
package isgbc_pkg;

   // averaging length, one offset per axis is sum / CAL_SAMPLES
   localparam int CAL_SAMPLES = 500;

   localparam int AXES      = 6;
   localparam int ACC_AXES  = 3;
   localparam int AXIS_ACC_Z = 2;

   localparam int SAMPLE_W  = 16;
   localparam int OFFSET_W  = 17;
   localparam int SUM_W     = 26;
   localparam int MAG_W     = 25;
   localparam int COUNT_W   = 9;
   localparam int RUN_W     = 8;
   localparam int THR_W     = 16;
   localparam int GRAV_W    = 15;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int REQ_TDATA_W = AXES * SAMPLE_W;
   localparam int RSP_ITEM_W  = AXES * SAMPLE_W + 2;
   localparam int RSP_TDATA_W = ((RSP_ITEM_W + 7) / 8) * 8;

   // reciprocal divide: q ~= (|sum| * DIV_MULT) >> DIV_SHIFT, then one fix-up
   localparam int DIV_SHIFT  = MAG_W;
   localparam int DIV_MULT_W = MAG_W + 1;
   localparam logic [DIV_MULT_W-1:0] DIV_MULT =
      DIV_MULT_W'((64'd1 << DIV_SHIFT) / CAL_SAMPLES);
   localparam logic [COUNT_W-1:0] CAL_COUNT = COUNT_W'(CAL_SAMPLES);
   // stages from the last averaged beat to the offset update
   localparam int DIV_STAGES = 4;

   // register reset values
   localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(200);
   localparam logic [RUN_W-1:0]  RUN_NEEDED_RST = RUN_W'(100);
   localparam logic [GRAV_W-1:0] GRAVITY_RST = GRAV_W'(4096);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STILL_THRESHOLD  = 2'd0,
      CSR_STILL_RUN_NEEDED = 2'd1,
      CSR_GRAVITY_COUNTS   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_RUN  = 2'd0,
      PH_WAIT = 2'd1,
      PH_AVG  = 2'd2
   } phase_type;

   // per-beat commands from the merge stage to every lane
   typedef struct packed {
      logic start;
      logic ref_load;
      logic sum_clear;
      logic sum_add;
      logic off_load;
   } lane_ctl_type;

   // result beat, axis 0 in the lowest bits, phase on top
   typedef struct packed {
      logic [1:0]                         phase;
      logic [AXES-1:0][SAMPLE_W-1:0]      axis;
   } rsp_item_type;

endpackage

### rtl/isgbc_lane.sv
// ----------------------------------------------------------------------------
// isgbc_lane : one axis of the calibration datapath
// Offset subtract, stillness compare, running sum and reciprocal divider.
// ----------------------------------------------------------------------------
module isgbc_lane (
   input  logic                                     clock,
   input  logic                                     reset,
   input  isgbc_pkg::lane_ctl_type                  ctl,
   input  logic signed [isgbc_pkg::SAMPLE_W-1:0]    raw,
   input  logic [isgbc_pkg::GRAV_W-1:0]             bias,
   input  logic [isgbc_pkg::THR_W-1:0]              threshold,
   output logic signed [isgbc_pkg::SAMPLE_W-1:0]    cur,
   output logic                                     still
);
   import isgbc_pkg::*;

   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic signed [SAMPLE_W-1:0] ref_ff;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [OFFSET_W-1:0] diff;
   logic [OFFSET_W-1:0]        diff_mag;

   logic [MAG_W-1:0]              mag_ff, mag2_ff, mag3_ff, qest_ff;
   logic                          neg_ff, neg2_ff, neg3_ff;
   logic [MAG_W+DIV_MULT_W-1:0]   prod_ff;
   logic [MAG_W+COUNT_W-1:0]      qd;
   logic [MAG_W-1:0]              rem, quot;
   logic [OFFSET_W-1:0]           quot_low;
   logic signed [OFFSET_W-1:0]    div_result;

   // corrected sample, offsets count as zero on a start beat
   assign cur = ctl.start ? raw : SAMPLE_W'(raw - offset_ff[SAMPLE_W-1:0]);

   // change against the previous sample
   assign diff     = OFFSET_W'(cur) - OFFSET_W'(ref_ff);
   assign diff_mag = diff[OFFSET_W-1] ? OFFSET_W'(-diff) : OFFSET_W'(diff);
   assign still    = diff_mag < {1'b0, threshold};

   // running sum with the gravity term removed
   assign sum_in = sum_ff + SUM_W'(cur) - SUM_W'(bias);

   always_ff @(posedge clock) begin
      if (ctl.ref_load) begin
         ref_ff <= cur;
      end
      if (ctl.sum_clear) begin
         sum_ff <= '0;
      end else if (ctl.sum_add) begin
         sum_ff <= sum_in;
      end
   end

   // divider: magnitude, reciprocal multiply, estimate, fix-up
   always_ff @(posedge clock) begin
      mag_ff  <= sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);
      neg_ff  <= sum_ff[SUM_W-1];
      prod_ff <= mag_ff * DIV_MULT;
      mag2_ff <= mag_ff;
      neg2_ff <= neg_ff;
      qest_ff <= prod_ff[DIV_SHIFT +: MAG_W];
      mag3_ff <= mag2_ff;
      neg3_ff <= neg2_ff;
   end

   // estimate is exact or one low, the remainder tells which
   assign qd         = qest_ff * CAL_COUNT;
   assign rem        = mag3_ff - qd[MAG_W-1:0];
   assign quot       = qest_ff + MAG_W'(rem >= MAG_W'(CAL_SAMPLES));
   assign quot_low   = quot[OFFSET_W-1:0];
   assign div_result = neg3_ff ? OFFSET_W'(-quot_low) : OFFSET_W'(quot_low);

   // offset register
   always_comb begin
      offset_in = offset_ff;
      if (ctl.start) begin
         offset_in = '0;
      end else if (ctl.off_load) begin
         offset_in = div_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

endmodule

### rtl/isgbc_ctrl.sv
// ----------------------------------------------------------------------------
// isgbc_ctrl : merge stage and phase sequencer
// Combines lane stillness, tracks run and sample counts, drives the lanes.
// ----------------------------------------------------------------------------
module isgbc_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  op_start,
   input  logic [isgbc_pkg::ACC_AXES-1:0]        still_acc,
   input  logic [isgbc_pkg::RUN_W-1:0]           run_needed,
   input  logic                                  sink_ready,
   output logic                                  req_tready,
   output logic                                  push,
   output isgbc_pkg::lane_ctl_type               lane_ctl,
   output isgbc_pkg::phase_type                  phase
);
   import isgbc_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [RUN_W-1:0]        run_ff, run_in, run_nxt;
   logic [COUNT_W-1:0]      count_ff, count_in, count_inc;
   logic [DIV_STAGES-1:0]   pipe_ff, pipe_in;
   logic                    div_go;
   logic                    all_still;

   // hold off input while the lane dividers run
   assign req_tready = sink_ready & ~(|pipe_ff);
   assign push       = req_tvalid & req_tready;
   assign all_still  = &still_acc;
   assign count_inc  = count_ff + COUNT_W'(1);
   assign phase      = phase_in;

   // next phase and lane commands
   always_comb begin
      phase_in = phase_ff;
      run_in   = run_ff;
      count_in = count_ff;
      run_nxt  = '0;
      div_go   = 1'b0;
      lane_ctl = '0;
      lane_ctl.off_load = pipe_ff[DIV_STAGES-1];
      if (push) begin
         if (op_start) begin
            lane_ctl.start     = 1'b1;
            lane_ctl.ref_load  = 1'b1;
            lane_ctl.sum_clear = 1'b1;
            run_in   = '0;
            count_in = '0;
            phase_in = (run_needed == '0) ? PH_AVG : PH_WAIT;
         end else begin
            case (phase_ff)
               PH_WAIT: begin
                  lane_ctl.ref_load = 1'b1;
                  run_nxt = all_still ? run_ff + RUN_W'(1) : '0;
                  run_in  = run_nxt;
                  if (run_nxt >= run_needed) begin
                     phase_in = PH_AVG;
                     count_in = '0;
                     lane_ctl.sum_clear = 1'b1;
                  end
               end
               PH_AVG: begin
                  lane_ctl.sum_add = 1'b1;
                  if (count_inc >= CAL_COUNT) begin
                     count_in = '0;
                     phase_in = PH_RUN;
                     div_go   = 1'b1;
                  end else begin
                     count_in = count_inc;
                  end
               end
               PH_RUN: begin
                  phase_in = PH_RUN;
               end
               default: begin
                  phase_in = PH_RUN;
               end
            endcase
         end
      end
      pipe_in = {pipe_ff[DIV_STAGES-2:0], div_go};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RUN;
         run_ff   <= '0;
         count_ff <= '0;
         pipe_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         run_ff   <= run_in;
         count_ff <= count_in;
         pipe_ff  <= pipe_in;
      end
   end

endmodule

### rtl/isgbc_skid.sv
// ----------------------------------------------------------------------------
// isgbc_skid : result register with one skid entry
// Keeps the input side running while a result beat waits downstream.
// ----------------------------------------------------------------------------
module isgbc_skid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  isgbc_pkg::rsp_item_type     push_data,
   output logic                        in_ready,
   output logic                        out_valid,
   input  logic                        out_ready,
   output isgbc_pkg::rsp_item_type     out_data
);
   import isgbc_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_data_ff, out_data_in;
   rsp_item_type skid_data_ff, skid_data_in;

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // refill the output register from skid first, else from the new beat
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

### rtl/imu_stillness_gated_bias_calibration.sv
// ----------------------------------------------------------------------------
// imu_stillness_gated_bias_calibration : six-axis imu zero-bias calibration
// Removes per-axis offsets from each sample; a start beat re-learns them
// after the accelerometer has been still for a run of samples.
// ----------------------------------------------------------------------------
//  channel   direction  ports                         content
//  req       in         req_tvalid/tready/tdata/tuser one raw six-axis sample
//  rsp       out        rsp_tvalid/tready/tdata       corrected sample + phase
//  csr       in         csr_we/addr/wdata             threshold, run, gravity
//
//  one sample beat per clock while req_tready is high; its result is
//  registered. six axis lanes work in parallel, a merge stage sequences
//  them. after the last averaged beat, req_tready stays low while each
//  lane's reciprocal-multiply divider (4 stages) sets the offset.
//  a one-entry skid keeps req open while one result waits on rsp_tready.
//  reset is synchronous and clears phase, counters, offsets and registers.
// ----------------------------------------------------------------------------
module imu_stillness_gated_bias_calibration (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: accel_x_raw, accel_y_raw, accel_z_raw,
   //            gyro_x_raw, gyro_y_raw, gyro_z_raw (16 bit each)
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [isgbc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_tuser: op (1 = start calibration)
   input  logic                                  req_tuser,
   // rsp_tdata: accel_x_out, accel_y_out, accel_z_out, gyro_x_out,
   //            gyro_y_out, gyro_z_out (16 bit each), phase (2 bit), zero pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [isgbc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                  csr_we,
   input  logic [isgbc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [isgbc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import isgbc_pkg::*;

   logic [THR_W-1:0]   threshold_ff;
   logic [RUN_W-1:0]   run_needed_ff;
   logic [GRAV_W-1:0]  gravity_ff;

   lane_ctl_type                lane_ctl;
   phase_type                   phase;
   logic                        push, sink_ready;
   logic [AXES-1:0]             still_axis;
   logic signed [SAMPLE_W-1:0]  cur [AXES];
   rsp_item_type                push_data, out_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RST;
         run_needed_ff <= RUN_NEEDED_RST;
         gravity_ff    <= GRAVITY_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_STILL_THRESHOLD:  threshold_ff  <= csr_wdata[THR_W-1:0];
            CSR_STILL_RUN_NEEDED: run_needed_ff <= csr_wdata[RUN_W-1:0];
            CSR_GRAVITY_COUNTS:   gravity_ff    <= csr_wdata[GRAV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // axis lanes, gravity comes off accel z only
   for (genvar i = 0; i < AXES; i++) begin : g_lane
      isgbc_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (lane_ctl),
         .raw       (req_tdata[i*SAMPLE_W +: SAMPLE_W]),
         .bias      ((i == AXIS_ACC_Z) ? gravity_ff : GRAV_W'(0)),
         .threshold (threshold_ff),
         .cur       (cur[i]),
         .still     (still_axis[i])
      );
      assign push_data.axis[i] = cur[i];
   end

   assign push_data.phase = phase;

   // merge stage and sequencer
   isgbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .op_start   (req_tuser),
      .still_acc  (still_axis[ACC_AXES-1:0]),
      .run_needed (run_needed_ff),
      .sink_ready (sink_ready),
      .req_tready (req_tready),
      .push       (push),
      .lane_ctl   (lane_ctl),
      .phase      (phase)
   );

   // result register and skid
   isgbc_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .in_ready  (sink_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = RSP_TDATA_W'(out_data);

endmodule

### rtl/isgbc_sva.sv
// ----------------------------------------------------------------------------
// isgbc_sva : port-level checks for the imu bias calibration block
// Watches the req and rsp beats; attached to the top level by bind.
// ----------------------------------------------------------------------------
module isgbc_sva (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [isgbc_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import isgbc_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // reset leaves no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // a result only appears after an accepted sample
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("rsp beat without a req beat");

   // a beat taken behind a stalled result fills the skid and closes req
   a_skid_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && req_tvalid && req_tready |=> !req_tready)
      else $error("req open with a full skid");

endmodule

bind imu_stillness_gated_bias_calibration isgbc_sva u_isgbc_sva (.*);

### tb/imu_stillness_gated_bias_calibration_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_stillness_gated_bias_calibration_test : self-checking bench for the
// imu bias calibration block
// Streams six-axis samples through req under random gaps and rsp stalls.
// A scoreboard tracks phase, stillness run, sums and offsets, and compares
// every result beat field by field. Several register settings are visited.
// ----------------------------------------------------------------------------
module imu_stillness_gated_bias_calibration_test;
   import isgbc_pkg::*;

   // ---------------------------------------------------------------------
   // expected-result tracker: follows the calibration state per sample
   // ---------------------------------------------------------------------
   class bias_scoreboard;
      logic [THR_W-1:0]  still_threshold;
      logic [RUN_W-1:0]  run_needed;
      logic [GRAV_W-1:0] gravity;
      phase_type         phase;
      logic [RUN_W-1:0]  still_run;
      int                ref_acc[ACC_AXES];
      int                avg_count;
      int                sums[AXES];
      int                offsets[AXES];
      rsp_item_type      corrected_q[$];
      string             axis_name[AXES];
      int                errors;
      int                checked;
      int                accepted;
      int                starts;
      int                calibrations;

      function new();
         still_threshold = THRESHOLD_RST;
         run_needed      = RUN_NEEDED_RST;
         gravity         = GRAVITY_RST;
         phase           = PH_RUN;
         still_run       = '0;
         avg_count       = 0;
         foreach (ref_acc[i]) ref_acc[i] = 0;
         foreach (sums[i]) begin
            sums[i]    = 0;
            offsets[i] = 0;
         end
         axis_name = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};
         errors = 0;
         checked = 0;
         accepted = 0;
         starts = 0;
         calibrations = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_STILL_THRESHOLD:  still_threshold = value[THR_W-1:0];
            CSR_STILL_RUN_NEEDED: run_needed      = value[RUN_W-1:0];
            CSR_GRAVITY_COUNTS:   gravity         = value[GRAV_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return corrected_q.size();
      endfunction

      // one accepted sample beat in, one expected result out
      function void note(logic op, logic [REQ_TDATA_W-1:0] data);
         int           raw[AXES];
         int           cur[AXES];
         int           wrapped;
         int           d;
         bit           still;
         rsp_item_type item;
         for (int i = 0; i < AXES; i++)
            raw[i] = int'($signed(data[i*SAMPLE_W +: SAMPLE_W]));
         accepted++;
         if (op) begin
            // start: offsets clear now, this accel becomes the reference
            starts++;
            for (int i = 0; i < AXES; i++) begin
               offsets[i] = 0;
               sums[i]    = 0;
               cur[i]     = raw[i];
            end
            for (int i = 0; i < ACC_AXES; i++) ref_acc[i] = raw[i];
            still_run = '0;
            avg_count = 0;
            phase = (run_needed == 0) ? PH_AVG : PH_WAIT;
         end else begin
            for (int i = 0; i < AXES; i++) cur[i] = raw[i] - offsets[i];
            case (phase)
               PH_WAIT: begin
                  // every accel axis must move less than the threshold
                  still = 1'b1;
                  for (int i = 0; i < ACC_AXES; i++) begin
                     wrapped = int'($signed(cur[i][SAMPLE_W-1:0]));
                     d = wrapped - ref_acc[i];
                     if (d < 0) d = -d;
                     if (d >= int'(still_threshold)) still = 1'b0;
                     ref_acc[i] = wrapped;
                  end
                  still_run = still ? still_run + 1'b1 : '0;
                  if (still_run >= run_needed) begin
                     phase     = PH_AVG;
                     avg_count = 0;
                     foreach (sums[i]) sums[i] = 0;
                  end
               end
               PH_AVG: begin
                  // accumulate, gravity off accel z, divide at the count
                  for (int i = 0; i < AXES; i++) begin
                     wrapped = int'($signed(cur[i][SAMPLE_W-1:0]));
                     if (i == AXIS_ACC_Z) wrapped -= int'(gravity);
                     sums[i] += wrapped;
                  end
                  avg_count++;
                  if (avg_count >= CAL_SAMPLES) begin
                     foreach (offsets[i]) offsets[i] = sums[i] / CAL_SAMPLES;
                     avg_count = 0;
                     phase = PH_RUN;
                     calibrations++;
                  end
               end
               default: phase = PH_RUN;
            endcase
         end
         for (int i = 0; i < AXES; i++) item.axis[i] = cur[i][SAMPLE_W-1:0];
         item.phase = phase;
         corrected_q.push_back(item);
      endfunction

      // compare one result beat with the oldest expectation
      function void check(logic [RSP_TDATA_W-1:0] data);
         rsp_item_type got;
         rsp_item_type want;
         got = rsp_item_type'(data[RSP_ITEM_W-1:0]);
         if (corrected_q.size() == 0) begin
            $display("%0t: result beat with nothing expected, got %h", $time, data);
            errors++;
            return;
         end
         want = corrected_q.pop_front();
         checked++;
         for (int i = 0; i < AXES; i++) begin
            if (got.axis[i] !== want.axis[i]) begin
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                        axis_name[i], $signed(want.axis[i]), $signed(got.axis[i]));
               errors++;
            end
         end
         if (got.phase !== want.phase) begin
            $display("%0t: phase mismatch, expected %0d, actual %0d", $time,
                     want.phase, got.phase);
            errors++;
         end
         if (data[RSP_TDATA_W-1:RSP_ITEM_W] !== '0) begin
            $display("%0t: pad bits mismatch, expected 0, actual %h", $time,
                     data[RSP_TDATA_W-1:RSP_ITEM_W]);
            errors++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bias_scoreboard sb = new();
   bit             stall_on = 1'b1;
   int             last_acc[ACC_AXES];
   int             bias[AXES];

   imu_stillness_gated_bias_calibration dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("%0t: timeout, %0d results still outstanding", $time, sb.pending());
      $display("Simulation FAILED");
      $finish;
   end

   // beat monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
      end
   end

   // result side back-pressure, a fresh stall drawn per beat
   initial begin
      int gap;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = stall_on ? $urandom_range(0, 3) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   function automatic int sat16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // drive one sample beat; called and returns at a falling edge
   task automatic send_axes(logic op, input int s[AXES]);
      logic [REQ_TDATA_W-1:0] data;
      int                     gap;
      for (int i = 0; i < AXES; i++) data[i*SAMPLE_W +: SAMPLE_W] = s[i][SAMPLE_W-1:0];
      for (int i = 0; i < ACC_AXES; i++) last_acc[i] = s[i];
      if ($urandom_range(0, 79) == 0) stall_on = !stall_on;
      gap = stall_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   task automatic send_list(logic op, int ax, int ay, int az, int gx, int gy, int gz);
      int s[AXES];
      s = '{ax, ay, az, gx, gy, gz};
      send_axes(op, s);
   endtask

   // register write while the block is idle, with csr_we dropped again afterwards
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, value);
      @(negedge clock);
   endtask

   // let every result drain, then cover the divider tail
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (2 * DIV_STAGES) @(negedge clock);
   endtask

   // next sample content from the predicted phase
   task automatic make_sample(bit wide, int break_pm, output int s[AXES]);
      int amp;
      int d;
      int jump_axis;
      int thr;
      thr = int'(sb.still_threshold);
      jump_axis = -1;
      if (sb.phase == PH_WAIT && thr > 0 && sb.still_run < 10 &&
          $urandom_range(0, 999) < break_pm)
         jump_axis = $urandom_range(0, ACC_AXES - 1);
      for (int i = 0; i < AXES; i++) begin
         if (wide) begin
            if ($urandom_range(0, 9) == 0) s[i] = $urandom_range(0, 1) ? 32767 : -32768;
            else s[i] = int'($signed(16'($urandom)));
         end else if (i < ACC_AXES && sb.phase == PH_WAIT) begin
            // random walk below the threshold, or one deliberate jump
            amp = (thr == 0) ? 0 : ((thr - 1 > 300) ? 300 : thr - 1);
            d = (i == jump_axis) ? thr : int'($urandom_range(0, 2 * amp)) - amp;
            s[i] = last_acc[i] + d;
            if (s[i] > 32767 || s[i] < -32768) s[i] = sat16(last_acc[i] - d);
         end else begin
            s[i] = sat16(bias[i] + int'($urandom_range(0, 120)) - 60);
         end
      end
   endtask

   // start a calibration and feed it until it ends or the limit is hit
   task automatic calibrate(bit wide, int break_pm, int limit);
      int s[AXES];
      int n;
      for (int i = 0; i < AXES; i++) bias[i] = int'($urandom_range(0, 6000)) - 3000;
      bias[AXIS_ACC_Z] = sat16(int'(sb.gravity) + int'($urandom_range(0, 600)) - 300);
      s = bias;
      send_axes(1'b1, s);
      n = 1;
      while (sb.phase != PH_RUN && n < limit) begin
         make_sample(wide, break_pm, s);
         send_axes(1'b0, s);
         n++;
      end
   endtask

   // full-range samples with occasional starts
   task automatic stir(int count, int start_pct);
      int s[AXES];
      repeat (count) begin
         make_sample(1'b1, 0, s);
         send_axes($urandom_range(0, 99) < start_pct, s);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: field extremes, bit patterns, threshold edges
      send_list(1'b0, 0, 0, 0, 0, 0, 0);
      send_list(1'b0, 32767, 32767, 32767, 32767, 32767, 32767);
      send_list(1'b0, -32768, -32768, -32768, -32768, -32768, -32768);
      send_list(1'b0, 'h5555, 'h5555, 'h5555, 'h5555, 'h5555, 'h5555);
      send_list(1'b0, -'h5556, -'h5556, -'h5556, -'h5556, -'h5556, -'h5556);
      send_list(1'b1, 100, -200, 4096, 32767, -32768, 1);
      send_list(1'b0, 299, -200, 4096, 5, -5, 0);
      send_list(1'b0, 299, -399, 4096, 5, -5, 0);
      send_list(1'b0, 299, -399, 4296, 5, -5, 0);
      send_list(1'b0, 299, -399, 4296, 5, -5, 0);
      send_list(1'b1, 0, 0, 4096, 0, 0, 0);
      send_list(1'b0, -32768, 32767, 0, 0, 0, 0);
      calibrate(1'b0, 30, 1200);
      stir(40, 10);
      drain();

      // zero threshold: nothing ever counts as still
      write_reg(CSR_STILL_THRESHOLD, 16'd0);
      write_reg(CSR_STILL_RUN_NEEDED, 16'd3);
      write_reg(CSR_GRAVITY_COUNTS, 16'd32767);
      calibrate(1'b0, 0, 6);
      drain();

      // zero run: start goes straight to averaging, full-range content
      write_reg(CSR_STILL_THRESHOLD, 16'd65535);
      write_reg(CSR_STILL_RUN_NEEDED, 16'd0);
      calibrate(1'b1, 0, 600);
      stir(30, 10);
      drain();

      // longest run at the tightest threshold, restarted mid-averaging
      write_reg(CSR_STILL_THRESHOLD, 16'd1);
      write_reg(CSR_STILL_RUN_NEEDED, 16'd255);
      write_reg(CSR_GRAVITY_COUNTS, 16'd0);
      calibrate(1'b0, 0, 275);
      stir(20, 50);
      drain();

      // short run, mixed traffic
      write_reg(CSR_STILL_THRESHOLD, 16'd500);
      write_reg(CSR_STILL_RUN_NEEDED, 16'd1);
      write_reg(CSR_GRAVITY_COUNTS, 16'd1000);
      calibrate(1'b0, 30, 60);
      stir(100, 8);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4 * DIV_STAGES) @(posedge clock);

      $display("covered %0d sample beats (%0d starts) and %0d checked results",
               sb.accepted, sb.starts, sb.checked);
      $display("over five register settings, %0d calibrations ran to completion",
               sb.calibrations);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

### files.f
rtl/isgbc_pkg.sv
rtl/isgbc_lane.sv
rtl/isgbc_ctrl.sv
rtl/isgbc_skid.sv
rtl/imu_stillness_gated_bias_calibration.sv
rtl/isgbc_sva.sv
tb/imu_stillness_gated_bias_calibration_test.sv
